/* hdl/lmbt_pkg.sv */
// ----------------------------------------------------------------------------
// lmbt_pkg: shared types and constants for the least-m binomial search
// Holds the effective-k limit, the test request/response bundles and the
// sequencer state types of both modules.
// ----------------------------------------------------------------------------
package lmbt_pkg;

  localparam int unsigned KW = 6;
  localparam logic [KW-1:0] MAX_K = 6'd32;
  localparam logic [KW-1:0] K_RESET = 6'd3;

  // request to the binomial test unit
  typedef struct packed {
    logic          start;
    logic [63:0]   n;
    logic [KW-1:0] k;
    logic [63:0]   th;
  } binom_req_t;

  // answer of the binomial test unit, valid for one cycle
  typedef struct packed {
    logic done;
    logic meets;
  } binom_rsp_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_CHECK
  } unit_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BR_TEST,
    S_BR_WAIT,
    S_BS_CHECK,
    S_BS_WAIT,
    S_FINISH
  } seq_state_t;

endpackage

/* hdl/lmbt_binom.sv */
// ----------------------------------------------------------------------------
// lmbt_binom: serial test C(n,k) >= th
// Builds C(n,k') one factor at a time with a shift-add multiplier and a
// restoring divider by the step index, exiting as soon as the running
// value meets the threshold or exceeds 64 bits.
// ----------------------------------------------------------------------------
module lmbt_binom (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lmbt_pkg::binom_req_t req,
  output lmbt_pkg::binom_rsp_t rsp
);

  lmbt_pkg::unit_state_t state_r, state_nxt;
  logic [63:0]  base_r, base_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic [63:0]  th_r, th_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [5:0]   kk_r, kk_nxt;
  logic [5:0]   i_r, i_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [4:0]   rem_r, rem_nxt;
  logic         done_r, done_nxt;
  logic         meets_r, meets_nxt;

  logic [63:0]  nk;
  logic [5:0]   kk_start;
  logic [64:0]  mul_sum;
  logic [5:0]   div_t;
  logic         div_ge;
  logic [5:0]   div_d;
  logic [63:0]  num_next;

  // clocked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmbt_pkg::U_IDLE;
      done_r  <= 1'b0;
      meets_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      meets_r <= meets_nxt;
    end
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    th_r   <= th_nxt;
    prod_r <= prod_nxt;
    kk_r   <= kk_nxt;
    i_r    <= i_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
  end

  // symmetric reduction and datapath helpers
  assign nk       = req.n - {58'd0, req.k};
  assign kk_start = (nk < {58'd0, req.k}) ? nk[5:0] : req.k;
  assign mul_sum  = {1'b0, prod_r[127:64]} + (prod_r[0] ? {1'b0, acc_r} : 65'd0);
  assign div_t    = {rem_r, prod_r[127]};
  assign div_ge   = div_t >= i_r;
  assign div_d    = div_t - i_r;
  assign num_next = base_r + {58'd0, i_r} + 64'd1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    th_nxt    = th_r;
    prod_nxt  = prod_r;
    kk_nxt    = kk_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    meets_nxt = meets_r;
    case (state_r)
      lmbt_pkg::U_IDLE: begin
        if (req.start) begin
          th_nxt   = req.th;
          kk_nxt   = kk_start;
          base_nxt = req.n - {58'd0, kk_start};
          acc_nxt  = 64'd1;
          i_nxt    = 6'd1;
          cnt_nxt  = 7'd0;
          prod_nxt = {64'd0, req.n - {58'd0, kk_start} + 64'd1};
          if ({58'd0, req.k} > req.n) begin
            done_nxt  = 1'b1;
            meets_nxt = (req.th == 64'd0);
          end else if (req.th <= 64'd1) begin
            done_nxt  = 1'b1;
            meets_nxt = 1'b1;
          end else if (kk_start == 6'd0) begin
            done_nxt  = 1'b1;
            meets_nxt = 1'b0;
          end else begin
            state_nxt = lmbt_pkg::U_MUL;
          end
        end
      end
      lmbt_pkg::U_MUL: begin
        // add and shift one multiplier bit
        prod_nxt = {mul_sum, prod_r[63:1]};
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r[5:0] == 6'd63) begin
          cnt_nxt   = 7'd0;
          rem_nxt   = 5'd0;
          state_nxt = lmbt_pkg::U_DIV;
        end
      end
      lmbt_pkg::U_DIV: begin
        // one quotient bit per cycle
        prod_nxt = {prod_r[126:0], div_ge};
        rem_nxt  = div_ge ? div_d[4:0] : div_t[4:0];
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          state_nxt = lmbt_pkg::U_CHECK;
        end
      end
      lmbt_pkg::U_CHECK: begin
        cnt_nxt = 7'd0;
        if (prod_r[127:64] != 64'd0 || prod_r[63:0] >= th_r) begin
          done_nxt  = 1'b1;
          meets_nxt = 1'b1;
          state_nxt = lmbt_pkg::U_IDLE;
        end else if (i_r == kk_r) begin
          done_nxt  = 1'b1;
          meets_nxt = 1'b0;
          state_nxt = lmbt_pkg::U_IDLE;
        end else begin
          acc_nxt   = prod_r[63:0];
          i_nxt     = i_r + 6'd1;
          prod_nxt  = {64'd0, num_next};
          state_nxt = lmbt_pkg::U_MUL;
        end
      end
      default: state_nxt = lmbt_pkg::U_IDLE;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.meets = meets_r;

  // step index stays inside the reduced k while working
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmbt_pkg::U_MUL) |-> (i_r != 6'd0 && i_r <= kk_r))
    else $error("step index out of range");

  // remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmbt_pkg::U_DIV) |-> ({1'b0, rem_r} < i_r))
    else $error("divider remainder not below divisor");

  // check only follows a full division
  a_check_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmbt_pkg::U_CHECK) |-> ($past(state_r) == lmbt_pkg::U_DIV))
    else $error("check without division");

endmodule

/* hdl/least_m_binomial_threshold_core.sv */
// ----------------------------------------------------------------------------
// least_m_binomial_threshold_core: least m with C(m,k) >= threshold
// Each threshold beat returns one least_m beat, the smallest m with
// C(m,k) >= threshold for the configured k (saturated at 32). k of zero
// gives 0, threshold of 0 or 1 gives k, k of one gives the threshold;
// these need no test. Otherwise an upper bound doubles from k, then a
// binary search runs; each probe is one binomial test in a single shared
// unit, each factor a shift-add multiply, a restoring divide and a check,
// k' = min(k, n-k) factors at most, fewer when the threshold is met
// early. A search makes up to about 128 probes. One item is worked at a
// time; a finished result sits in an output register so the next threshold
// can be taken while it waits. Write cfg_choose_k only while idle.
// ----------------------------------------------------------------------------
module least_m_binomial_threshold_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_choose_k,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_threshold,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_least_m
);

  lmbt_pkg::seq_state_t state_r, state_nxt;
  logic [5:0]  choose_k_r;
  logic [5:0]  k_r, k_nxt;
  logic [63:0] th_r, th_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic [63:0] mid_r, mid_nxt;
  logic [63:0] res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_least_m_r, out_least_m_nxt;
  logic [5:0]  k_eff;
  logic [63:0] mid_calc;
  lmbt_pkg::binom_req_t req;
  lmbt_pkg::binom_rsp_t rsp;

  lmbt_binom u_binom (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      choose_k_r <= lmbt_pkg::K_RESET;
    end else if (cfg_we) begin
      choose_k_r <= cfg_choose_k;
    end
  end

  // clocked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmbt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r           <= k_nxt;
    th_r          <= th_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    res_r         <= res_nxt;
    out_least_m_r <= out_least_m_nxt;
  end

  assign k_eff    = (choose_k_r > lmbt_pkg::MAX_K) ? lmbt_pkg::MAX_K : choose_k_r;
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  // search sequencer
  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    th_nxt          = th_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_least_m_nxt = out_least_m_r;
    req.start       = 1'b0;
    req.n           = hi_r;
    req.k           = k_r;
    req.th          = th_r;
    case (state_r)
      lmbt_pkg::S_IDLE: begin
        if (in_valid) begin
          k_nxt     = k_eff;
          th_nxt    = in_threshold;
          lo_nxt    = {58'd0, k_eff};
          hi_nxt    = {58'd0, k_eff};
          state_nxt = lmbt_pkg::S_FINISH;
          if (k_eff == 6'd0) begin
            res_nxt = 64'd0;
          end else if (in_threshold <= 64'd1) begin
            res_nxt = {58'd0, k_eff};
          end else if (k_eff == 6'd1) begin
            res_nxt = in_threshold;
          end else begin
            state_nxt = lmbt_pkg::S_BR_TEST;
          end
        end
      end
      lmbt_pkg::S_BR_TEST: begin
        req.start = 1'b1;
        state_nxt = lmbt_pkg::S_BR_WAIT;
      end
      lmbt_pkg::S_BR_WAIT: begin
        // double hi until it meets or passes half range
        if (rsp.done) begin
          if (rsp.meets || hi_r[63]) begin
            state_nxt = lmbt_pkg::S_BS_CHECK;
          end else begin
            hi_nxt    = {hi_r[62:0], 1'b0};
            state_nxt = lmbt_pkg::S_BR_TEST;
          end
        end
      end
      lmbt_pkg::S_BS_CHECK: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          req.n     = mid_calc;
          req.start = 1'b1;
          state_nxt = lmbt_pkg::S_BS_WAIT;
        end else begin
          res_nxt   = lo_r;
          state_nxt = lmbt_pkg::S_FINISH;
        end
      end
      lmbt_pkg::S_BS_WAIT: begin
        if (rsp.done) begin
          if (rsp.meets) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r + 64'd1;
          end
          state_nxt = lmbt_pkg::S_BS_CHECK;
        end
      end
      lmbt_pkg::S_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_least_m_nxt = res_r;
          state_nxt       = lmbt_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmbt_pkg::S_IDLE;
    endcase
  end

  assign in_stall    = (state_r != lmbt_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_least_m = out_least_m_r;

endmodule
